/* design/srr_pkg.sv */
package srr_pkg;

   localparam int SEQ_SPACE_DEF    = 8;
   localparam int PAYLOAD_BITS_DEF = 64;
   localparam int MAX_WINDOW       = 4;

   localparam int WIN_W    = 3;
   localparam int SEQ_IN_W = 3;
   localparam int PAY_IN_W = 64;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd4;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef struct packed {
      logic                load;
      logic                kind;
      logic [PAY_IN_W-1:0] payload;
      logic [SEQ_IN_W-1:0] ack;
      logic                last;
   } result_type;

endpackage

/* design/srr_ram.sv */
module srr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/srr_out.sv */
module srr_out import srr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  result_type          res,
   output logic                slot_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [PAY_IN_W-1:0] rsp_delivered_payload,
   output logic [SEQ_IN_W-1:0] rsp_ack_number,
   output logic                rsp_last_result
);

   logic                valid_ff, valid_in;
   logic                kind_ff;
   logic [PAY_IN_W-1:0] payload_ff;
   logic [SEQ_IN_W-1:0] ack_ff;
   logic                last_ff;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = res.load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && res.load) begin
         kind_ff    <= res.kind;
         payload_ff <= res.payload;
         ack_ff     <= res.ack;
         last_ff    <= res.last;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_result_kind       = kind_ff;
   assign rsp_delivered_payload = payload_ff;
   assign rsp_ack_number        = ack_ff;
   assign rsp_last_result       = last_ff;

endmodule

/* design/srr_seq.sv */
module srr_seq import srr_pkg::*; #(
   parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [WIN_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_checksum_ok,
   input  logic [SEQ_IN_W-1:0] req_seq_number,
   input  logic [PAY_IN_W-1:0] req_payload_word,
   input  logic                slot_free,
   output result_type          res
);

   localparam int SEQ_W    = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
   localparam int WIN_HALF = SEQ_SPACE / 2;
   localparam int WIN_LIM  = (WIN_HALF > MAX_WINDOW) ? MAX_WINDOW :
                             ((WIN_HALF < 1) ? 1 : WIN_HALF);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_ACK   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [SEQ_W-1:0]        exp_ff, exp_in;
   logic [SEQ_SPACE-1:0]    flags_ff, flags_in;
   logic [WIN_W-1:0]        window_ff, window_in;
   logic [WIN_W-1:0]        cnt_ff, cnt_in;
   logic [SEQ_IN_W-1:0]     seq_ff, seq_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;

   logic                    accept;
   logic                    in_range;
   logic [SEQ_W-1:0]        seq_idx;
   logic [SEQ_W:0]          seq_ext, exp_ext, offset;
   logic                    match;
   logic                    in_window;
   logic [WIN_W-1:0]        w_eff;
   logic [SEQ_W-1:0]        exp_next;
   logic                    wr_en;
   logic                    rd_en;
   logic [PAYLOAD_BITS-1:0] rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // effective window: zero acts as one, saturate at the limit
   always_comb begin
      if (window_ff == '0) begin
         w_eff = WIN_W'(1);
      end else if (32'(window_ff) > WIN_LIM) begin
         w_eff = WIN_W'(WIN_LIM);
      end else begin
         w_eff = window_ff;
      end
   end

   assign in_range = 32'(req_seq_number) < SEQ_SPACE;
   assign seq_idx  = SEQ_W'(req_seq_number);
   assign match    = in_range && (seq_idx == exp_ff);
   assign seq_ext  = (SEQ_W+1)'(seq_idx);
   assign exp_ext  = (SEQ_W+1)'(exp_ff);
   assign offset   = (seq_ext >= exp_ext) ? (seq_ext - exp_ext)
                                          : (seq_ext + (SEQ_W+1)'(SEQ_SPACE) - exp_ext);
   assign in_window = 32'(offset) < 32'(w_eff);
   assign exp_next  = (exp_ff == SEQ_W'(SEQ_SPACE - 1)) ? '0 : exp_ff + SEQ_W'(1);

   assign wr_en = accept && req_checksum_ok && in_range && !match && in_window;

   always_comb begin
      state_in  = state_ff;
      exp_in    = exp_ff;
      flags_in  = flags_ff;
      window_in = window_ff;
      cnt_in    = cnt_ff;
      seq_in    = seq_ff;
      pay_in    = pay_ff;
      rd_en     = 1'b0;
      res       = '0;

      if (csr_write_enable) begin
         window_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_checksum_ok) begin
               seq_in = req_seq_number;
               pay_in = PAYLOAD_BITS'(req_payload_word);
               if (match) begin
                  state_in = ST_HEAD;
               end else begin
                  if (wr_en) begin
                     flags_in[seq_idx] = 1'b1;
                  end
                  state_in = ST_ACK;
               end
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               res.load         = 1'b1;
               res.kind         = KIND_DELIVER;
               res.payload      = PAY_IN_W'(pay_ff);
               flags_in[exp_ff] = 1'b0;
               exp_in           = exp_next;
               cnt_in           = WIN_W'(1);
               state_in         = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((cnt_ff < w_eff) && flags_ff[exp_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_READ: begin
            if (slot_free) begin
               res.load         = 1'b1;
               res.kind         = KIND_DELIVER;
               res.payload      = PAY_IN_W'(rd_data);
               flags_in[exp_ff] = 1'b0;
               exp_in           = exp_next;
               cnt_in           = cnt_ff + WIN_W'(1);
               state_in         = ST_CHECK;
            end
         end
         ST_ACK: begin
            if (slot_free) begin
               res.load = 1'b1;
               res.kind = KIND_ACK;
               res.ack  = seq_ff;
               res.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         exp_ff    <= '0;
         flags_ff  <= '0;
         window_ff <= WINDOW_RESET;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         exp_ff    <= exp_in;
         flags_ff  <= flags_in;
         window_ff <= window_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      pay_ff <= pay_in;
   end

   srr_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_SPACE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (seq_idx),
      .wr_data (PAYLOAD_BITS'(req_payload_word)),
      .rd_en   (rd_en),
      .rd_addr (exp_ff),
      .rd_data (rd_data)
   );

endmodule

/* design/selective_repeat_receiver.sv */
// Selective-repeat receiver.
// req_*: one packet per transfer (checksum flag, sequence number, payload),
//   taken when req_valid is high and req_stall low. req_stall stays high
//   while a packet is being worked on.
// rsp_*: results, one per transfer. An in-order packet gives its own payload,
//   then any buffered payloads that follow it, then an ack with last_result set.
//   Any other good packet gives the ack alone; a corrupt one gives nothing.
// csr_*: window width, written when csr_write_enable is high. The user must
//   write it only while the block is idle; the block does not enforce this.
// An in-order packet releases at most window - 1 buffered payloads (window as
//   clamped by the sequencer). The sequencer walks the store entry by entry
//   (flag check, then registered RAM read).
// The first result goes through the sequencer state, then the output register.
// A stall on rsp_* holds the output register and the sequencer until taken.
// Reset (synchronous) clears the expected number, the receive flags and the
//   output valid, and sets the window to 4; the payload store needs no clear.
module selective_repeat_receiver import srr_pkg::*; #(
   parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [WIN_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_checksum_ok,
   input  logic [SEQ_IN_W-1:0] req_seq_number,
   input  logic [PAY_IN_W-1:0] req_payload_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [PAY_IN_W-1:0] rsp_delivered_payload,
   output logic [SEQ_IN_W-1:0] rsp_ack_number,
   output logic                rsp_last_result
);

   result_type res;
   logic       slot_free;

   srr_seq #(
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_checksum_ok  (req_checksum_ok),
      .req_seq_number   (req_seq_number),
      .req_payload_word (req_payload_word),
      .slot_free        (slot_free),
      .res              (res)
   );

   srr_out u_out (
      .clock                 (clock),
      .reset                 (reset),
      .res                   (res),
      .slot_free             (slot_free),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_delivered_payload (rsp_delivered_payload),
      .rsp_ack_number        (rsp_ack_number),
      .rsp_last_result       (rsp_last_result)
   );

`ifndef NO_ASSERTIONS
   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_result == rsp_result_kind))
      else $error("last_result and result_kind disagree");

   a_ack_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_ACK) |-> (rsp_delivered_payload == '0))
      else $error("ack carries a payload");

   a_deliver_no_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_DELIVER) |-> (rsp_ack_number == '0))
      else $error("delivery carries an ack number");

   a_busy_after_good: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_checksum_ok) |=> req_stall)
      else $error("good packet did not occupy the sequencer");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb import srr_pkg::*; ();

   typedef struct packed {
      logic                ok;
      logic [SEQ_IN_W-1:0] seq;
      logic [PAY_IN_W-1:0] pay;
   } packet_type;

   typedef struct packed {
      logic                kind;
      logic [PAY_IN_W-1:0] payload;
      logic [SEQ_IN_W-1:0] ack;
      logic                last;
   } outcome_type;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_ITEMS    = 56;
   localparam int IDLE_PCT       = 29;
   localparam logic [PAY_IN_W-1:0] ALL_ONES = '1;
   localparam logic [8*WIN_W-1:0] WINDOW_PLAN =
      {3'd2, 3'd5, 3'd6, 3'd4, 3'd1, 3'd3, 3'd7, 3'd0};

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [WIN_W-1:0]    csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_checksum_ok  = 1'b0;
   logic [SEQ_IN_W-1:0] req_seq_number   = '0;
   logic [PAY_IN_W-1:0] req_payload_word = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic                rsp_result_kind;
   logic [PAY_IN_W-1:0] rsp_delivered_payload;
   logic [SEQ_IN_W-1:0] rsp_ack_number;
   logic                rsp_last_result;

   packet_type  pkt_backlog[$];
   outcome_type due_results[$];
   packet_type  on_bus;
   int          pushed_pkts     = 0;
   int          good_pkts       = 0;
   int          taken_pkts      = 0;
   int          checked_results = 0;
   int          mismatches      = 0;
   int          idle_cycles     = 0;
   bit          no_gaps         = 1'b0;

   // receiver state as the block should hold it
   logic [SEQ_IN_W-1:0]      next_seq    = '0;
   logic [SEQ_SPACE_DEF-1:0] held_flags  = '0;
   logic [PAY_IN_W-1:0]      held_payload [0:SEQ_SPACE_DEF-1];
   logic [WIN_W-1:0]         win_setting = WINDOW_RESET;

   selective_repeat_receiver u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_checksum_ok       (req_checksum_ok),
      .req_seq_number        (req_seq_number),
      .req_payload_word      (req_payload_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_delivered_payload (rsp_delivered_payload),
      .rsp_ack_number        (rsp_ack_number),
      .rsp_last_result       (rsp_last_result)
   );

   initial forever #1 clock = ~clock;

   function automatic int span_of(logic [WIN_W-1:0] v);
      int lim;
      lim = (SEQ_SPACE_DEF / 2 < MAX_WINDOW) ? SEQ_SPACE_DEF / 2 : MAX_WINDOW;
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
   endfunction

   function automatic outcome_type make_outcome(logic kind, logic [PAY_IN_W-1:0] pay,
                                                logic [SEQ_IN_W-1:0] ack, logic last);
      outcome_type o;
      o.kind    = kind;
      o.payload = pay;
      o.ack     = ack;
      o.last    = last;
      return o;
   endfunction

   function automatic void receive_packet(packet_type p);
      int                  w;
      int                  released;
      logic [SEQ_IN_W-1:0] off;
      w        = span_of(win_setting);
      released = 0;
      off      = p.seq - next_seq;
      if (!p.ok) return;
      if (p.seq == next_seq) begin
         due_results.push_back(make_outcome(KIND_DELIVER, p.pay, '0, 1'b0));
         held_flags[next_seq] = 1'b0;
         next_seq = next_seq + 1'b1;
         while (released + 1 < w && held_flags[next_seq]) begin
            due_results.push_back(make_outcome(KIND_DELIVER, held_payload[next_seq], '0, 1'b0));
            held_flags[next_seq] = 1'b0;
            next_seq = next_seq + 1'b1;
            released++;
         end
      end else if (off < w) begin
         held_payload[p.seq] = p.pay;
         held_flags[p.seq]   = 1'b1;
      end
      due_results.push_back(make_outcome(KIND_ACK, '0, p.seq, 1'b1));
   endfunction

   function automatic logic [PAY_IN_W-1:0] rand_payload();
      case ($urandom_range(15))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic log_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_packet(logic ok, logic [SEQ_IN_W-1:0] seq, logic [PAY_IN_W-1:0] pay);
      packet_type p;
      p.ok  = ok;
      p.seq = seq;
      p.pay = pay;
      pkt_backlog.push_back(p);
      pushed_pkts++;
      if (ok) good_pkts++;
   endtask

   task automatic drain();
      while (taken_pkts != pushed_pkts || due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(logic [WIN_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      win_setting = v;
   endtask

   // a shuffled pass over the window with corrupt copies and stale repeats, or a random burst
   task automatic send_batch();
      logic [SEQ_IN_W-1:0] order [0:MAX_WINDOW-1];
      logic [SEQ_IN_W-1:0] tmp;
      int                  w;
      int                  j;
      while (taken_pkts != pushed_pkts) @(posedge clock);
      w = span_of(win_setting);
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(4, 1))
            queue_packet(1'($urandom_range(1)), SEQ_IN_W'($urandom_range(7)),
                         rand_payload());
         return;
      end
      for (int i = 0; i < w; i++) order[i] = next_seq + SEQ_IN_W'(i);
      for (int i = w - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < w; i++) begin
         if ($urandom_range(9) == 0) queue_packet(1'b0, order[i], rand_payload());
         if ($urandom_range(11) == 0) begin
            tmp = next_seq - SEQ_IN_W'(1 + $urandom_range(3));
            queue_packet(1'b1, tmp, rand_payload());
         end
         queue_packet(1'b1, order[i], rand_payload());
      end
   endtask

   always @(posedge clock) begin : packet_driver
      packet_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            receive_packet(on_bus);
            taken_pkts++;
         end
         if (pkt_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
            nxt    = pkt_backlog.pop_front();
            on_bus = nxt;
            req_valid        <= 1'b1;
            req_checksum_ok  <= nxt.ok;
            req_seq_number   <= nxt.seq;
            req_payload_word <= nxt.pay;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               log_mismatch($sformatf("result with nothing outstanding, kind %0d ack %0d",
                                      rsp_result_kind, rsp_ack_number));
            end else begin
               want = due_results.pop_front();
               checked_results++;
               if (rsp_result_kind !== want.kind)
                  log_mismatch($sformatf("kind %0d, want %0d", rsp_result_kind, want.kind));
               if (rsp_delivered_payload !== want.payload)
                  log_mismatch($sformatf("payload %h, want %h",
                                         rsp_delivered_payload, want.payload));
               if (rsp_ack_number !== want.ack)
                  log_mismatch($sformatf("ack %0d, want %0d", rsp_ack_number, want.ack));
               if (rsp_last_result !== want.last)
                  log_mismatch($sformatf("last %0d, want %0d", rsp_last_result, want.last));
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, due_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // in-order, buffered, outside window, stale and corrupt packets at reset width
      queue_packet(1'b0, 3'd0, ALL_ONES);
      queue_packet(1'b1, 3'd0, '0);
      queue_packet(1'b1, 3'd3, ALL_ONES);
      queue_packet(1'b1, 3'd2, 64'h0123_4567_89ab_cdef);
      queue_packet(1'b1, 3'd4, 64'h8000_0000_0000_0001);
      queue_packet(1'b1, 3'd5, rand_payload());
      queue_packet(1'b1, 3'd0, rand_payload());
      queue_packet(1'b0, 3'd1, rand_payload());
      queue_packet(1'b1, 3'd1, 64'hfedc_ba98_7654_3210);
      queue_packet(1'b0, 3'd5, '0);
      queue_packet(1'b1, 3'd7, 64'h5555_aaaa_5555_aaaa);
      drain();
      // flag at 7 outlives a shrink to one slot
      set_window(3'd1);
      queue_packet(1'b1, 3'd5, rand_payload());
      queue_packet(1'b1, 3'd0, rand_payload());
      drain();
      set_window(3'd2);
      queue_packet(1'b1, 3'd6, rand_payload());

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         set_window(WINDOW_PLAN[phase*WIN_W +: WIN_W]);
         no_gaps = (phase == 3);
         start   = pushed_pkts;
         while (pushed_pkts - start < PHASE_ITEMS) send_batch();
      end
      drain();

      $display("%0d packets sent (%0d good), %0d results checked, %0d mismatches",
               pushed_pkts, good_pkts, checked_results, mismatches);
      $display("window widths 0 to 7 used; release runs, stale acks and leftover flags hit");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
design/srr_pkg.sv
design/srr_ram.sv
design/srr_out.sv
design/srr_seq.sv
design/selective_repeat_receiver.sv
verif/tb.sv
